/* rtl/core/pea_pkg.sv */
// ----------------------------------------------------------------------------
// pea_pkg: shared types and constants of the page extent allocator
// Holds the result status codes, the operation codes and the control state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package pea_pkg;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE = 3'd1;
   localparam logic [2:0] ST_NO_FIT   = 3'd2;
   localparam logic [2:0] ST_ALREADY  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN_A,
      S_MID,
      S_FCLIP,
      S_SCAN_R,
      S_RCLIP,
      S_DECIDE,
      S_MERGE,
      S_WRITE,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/pea_cell.sv */
// ----------------------------------------------------------------------------
// pea_cell: one slot of the extent ring
// Holds one extent and passes it to its neighbor on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module pea_cell #(
   parameter int ADDR_BITS = 48
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift,
   input  wire logic                 in_valid,
   input  wire logic [ADDR_BITS-1:0] in_start,
   input  wire logic [ADDR_BITS:0]   in_length,
   output logic                      out_valid,
   output logic [ADDR_BITS-1:0]      out_start,
   output logic [ADDR_BITS:0]        out_length
);

   logic                 valid_ff;
   logic [ADDR_BITS-1:0] start_ff;
   logic [ADDR_BITS:0]   length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= in_valid;
      end
   end

   // payload needs no reset: read only while valid
   always_ff @(posedge clock) begin
      if (shift) begin
         start_ff  <= in_start;
         length_ff <= in_length;
      end
   end

   assign out_valid  = valid_ff;
   assign out_start  = start_ff;
   assign out_length = length_ff;

endmodule

`default_nettype wire

/* rtl/core/page_extent_allocator.sv */
// ----------------------------------------------------------------------------
// page_extent_allocator: best fit page extent allocator with coalescing
// Free extents sit in a ring that rotates one slot per cycle in the scan and
// write states past a head where a single scanner compares and rewrites them.
// ----------------------------------------------------------------------------
// An allocate scans the ring once for the best fit, then rewrites it; a free
// scans once for the left neighbor, once for the right neighbor and the first
// empty slot, then rewrites it; a bad size goes straight to the rewrite pass.
// One request at a time: busy drops in the strobe cycle, so a new word may
// follow at the edge ending it. PAGE_BYTES must be a power of two.
// Reset empties the table and zeroes the free total at once; no stall.
`default_nettype none

module page_extent_allocator #(
   parameter int MAX_EXTENTS = 64,
   parameter int ADDR_BITS   = 48,
   parameter int PAGE_BYTES  = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_op,
   input  wire logic [ADDR_BITS-1:0] req_region_address,
   input  wire logic [ADDR_BITS:0]   req_region_bytes,
   output logic                      rsp_valid,
   output logic [ADDR_BITS-1:0]      rsp_granted_address,
   output logic [2:0]                rsp_status,
   output logic [ADDR_BITS:0]        rsp_total_free_bytes,
   output logic [ADDR_BITS:0]        rsp_largest_free_bytes
);

   localparam int A  = ADDR_BITS;
   localparam int L  = ADDR_BITS + 1;
   localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_EXTENTS - 1);
   localparam logic [L-1:0]  ADDR_LIMIT = {1'b1, {A{1'b0}}};
   localparam logic [L-1:0]  PAGE_MASK = L'(PAGE_BYTES - 1);

   // ring of cells: cell k takes from cell k+1, the last from the head logic
   logic [MAX_EXTENTS-1:0] c_valid;
   logic [A-1:0]           c_start  [MAX_EXTENTS];
   logic [L-1:0]           c_length [MAX_EXTENTS];
   logic                   ring_shift;
   logic                   w_valid;
   logic [A-1:0]           w_start;
   logic [L-1:0]           w_length;

   genvar k;
   generate
      for (k = 0; k < MAX_EXTENTS; k++) begin : g_ring
         if (k == MAX_EXTENTS - 1) begin : g_tail
            pea_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
               .clock(clock), .reset(reset), .shift(ring_shift),
               .in_valid(w_valid), .in_start(w_start), .in_length(w_length),
               .out_valid(c_valid[k]), .out_start(c_start[k]),
               .out_length(c_length[k])
            );
         end else begin : g_mid
            pea_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
               .clock(clock), .reset(reset), .shift(ring_shift),
               .in_valid(c_valid[k+1]), .in_start(c_start[k+1]),
               .in_length(c_length[k+1]),
               .out_valid(c_valid[k]), .out_start(c_start[k]),
               .out_length(c_length[k])
            );
         end
      end
   endgenerate

   logic         h_valid;
   logic [A-1:0] h_start;
   logic [L-1:0] h_length;
   assign h_valid  = c_valid[0];
   assign h_start  = c_start[0];
   assign h_length = c_length[0];

   // control and working registers
   pea_pkg::state_type state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          op_ff, op_in;
   logic [L-1:0]  lo_ff, lo_in, hi_ff, hi_in, size_ff, size_in;
   logic          found_ff, found_in;
   logic [IW-1:0] bidx_ff, bidx_in;
   logic [A-1:0]  bstart_ff, bstart_in;
   logic [L-1:0]  blen_ff, blen_in;
   logic          rfound_ff, rfound_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic [A-1:0]  rstart_ff, rstart_in;
   logic [L-1:0]  rlen_ff, rlen_in;
   logic          sfound_ff, sfound_in;
   logic [IW-1:0] sidx_ff, sidx_in;
   logic [L:0]    lend_ff, lend_in;
   logic          ladj_ff, ladj_in, radj_ff, radj_in, exact_ff, exact_in;
   logic [L-1:0]  delta_ff, delta_in, addlen_ff, addlen_in, nlen_ff, nlen_in;
   logic [L-1:0]  largest_ff, largest_in, total_ff, total_in;
   logic [2:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [A-1:0]  granted_ff, granted_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [L-1:0]  rsp_total_ff, rsp_total_in, rsp_largest_ff, rsp_largest_in;

   logic [L:0]    req_end;
   logic [L-1:0]  base_largest;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pea_pkg::S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      op_ff <= op_in;     lo_ff <= lo_in;       hi_ff <= hi_in;
      size_ff <= size_in; found_ff <= found_in; bidx_ff <= bidx_in;
      bstart_ff <= bstart_in; blen_ff <= blen_in;
      rfound_ff <= rfound_in; ridx_ff <= ridx_in;
      rstart_ff <= rstart_in; rlen_ff <= rlen_in;
      sfound_ff <= sfound_in; sidx_ff <= sidx_in; lend_ff <= lend_in;
      ladj_ff <= ladj_in; radj_ff <= radj_in; exact_ff <= exact_in;
      delta_ff <= delta_in; addlen_ff <= addlen_in; nlen_ff <= nlen_in;
      largest_ff <= largest_in; status_ff <= status_in;
      granted_ff <= granted_in; rsp_status_ff <= rsp_status_in;
      rsp_total_ff <= rsp_total_in; rsp_largest_ff <= rsp_largest_in;
   end

   always_comb begin
      // hold by default
      state_in = state_ff;   cnt_in = cnt_ff;
      op_in = op_ff;         lo_in = lo_ff;
      hi_in = hi_ff;         size_in = size_ff;     found_in = found_ff;
      bidx_in = bidx_ff;     bstart_in = bstart_ff; blen_in = blen_ff;
      rfound_in = rfound_ff; ridx_in = ridx_ff;     rstart_in = rstart_ff;
      rlen_in = rlen_ff;     sfound_in = sfound_ff; sidx_in = sidx_ff;
      lend_in = lend_ff;     ladj_in = ladj_ff;     radj_in = radj_ff;
      exact_in = exact_ff;   delta_in = delta_ff;   addlen_in = addlen_ff;
      nlen_in = nlen_ff;     largest_in = largest_ff; total_in = total_ff;
      status_in = status_ff; granted_in = granted_ff;
      rsp_status_in = rsp_status_ff; rsp_total_in = rsp_total_ff;
      rsp_largest_in = rsp_largest_ff;
      rsp_valid_in = 1'b0;
      ring_shift = 1'b0;
      w_valid = h_valid;  w_start = h_start;  w_length = h_length;
      req_end = '0;
      base_largest = '0;

      unique case (state_ff)
         pea_pkg::S_IDLE: begin
            if (start) begin
               op_in   = req_op;
               lo_in   = {1'b0, req_region_address};
               size_in = req_region_bytes;
               req_end = {2'b00, req_region_address} + {1'b0, req_region_bytes};
               hi_in   = (req_end > {1'b0, ADDR_LIMIT}) ? ADDR_LIMIT : req_end[L-1:0];
               state_in = pea_pkg::S_CHECK;
            end
         end

         // reject a zero size or one with bits below the page size
         pea_pkg::S_CHECK: begin
            cnt_in = '0;
            found_in = 1'b0;
            status_in = pea_pkg::ST_OK;
            if (size_ff == '0 || (size_ff & PAGE_MASK) != '0) begin
               status_in = pea_pkg::ST_BAD_SIZE;
               state_in  = pea_pkg::S_WRITE;
            end else begin
               state_in = pea_pkg::S_SCAN_A;
            end
         end

         // best fit on allocate, left neighbor on free
         pea_pkg::S_SCAN_A: begin
            ring_shift = 1'b1;
            if (op_ff == pea_pkg::OP_ALLOC) begin
               if (h_valid && h_length >= size_ff &&
                   (!found_ff || h_length < blen_ff ||
                    (h_length == blen_ff && h_start < bstart_ff))) begin
                  found_in = 1'b1; bidx_in = cnt_ff;
                  bstart_in = h_start; blen_in = h_length;
               end
            end else begin
               if (h_valid && {1'b0, h_start} <= lo_ff &&
                   (!found_ff || h_start > bstart_ff)) begin
                  found_in = 1'b1; bidx_in = cnt_ff;
                  bstart_in = h_start; blen_in = h_length;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in = '0;
               state_in = pea_pkg::S_MID;
            end
         end

         pea_pkg::S_MID: begin
            if (op_ff == pea_pkg::OP_ALLOC) begin
               nlen_in  = blen_ff - size_ff;
               exact_in = (blen_ff == size_ff);
               if (!found_ff) begin
                  status_in = pea_pkg::ST_NO_FIT;
               end
               state_in = pea_pkg::S_WRITE;
            end else begin
               lend_in  = {2'b00, bstart_ff} + {1'b0, blen_ff};
               state_in = pea_pkg::S_FCLIP;
            end
         end

         // clip the low end against the left neighbor, or report already free if it covers the range
         pea_pkg::S_FCLIP: begin
            rfound_in = 1'b0;
            sfound_in = 1'b0;
            state_in  = pea_pkg::S_SCAN_R;
            if (found_ff) begin
               if (lend_ff >= {1'b0, hi_ff}) begin
                  status_in = pea_pkg::ST_ALREADY;
                  state_in  = pea_pkg::S_WRITE;
               end else if (lend_ff > {1'b0, lo_ff}) begin
                  lo_in = lend_ff[L-1:0];
               end
            end
         end

         // right neighbor and first empty slot
         pea_pkg::S_SCAN_R: begin
            ring_shift = 1'b1;
            if (h_valid && {1'b0, h_start} >= lo_ff &&
                (!rfound_ff || h_start < rstart_ff)) begin
               rfound_in = 1'b1; ridx_in = cnt_ff;
               rstart_in = h_start; rlen_in = h_length;
            end
            if (!h_valid && !sfound_ff) begin
               sfound_in = 1'b1; sidx_in = cnt_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in = '0;
               state_in = pea_pkg::S_RCLIP;
            end
         end

         pea_pkg::S_RCLIP: begin
            state_in = pea_pkg::S_DECIDE;
            if (rfound_ff) begin
               if ({1'b0, rstart_ff} == lo_ff) begin
                  status_in = pea_pkg::ST_ALREADY;
                  state_in  = pea_pkg::S_WRITE;
               end else if (hi_ff > {1'b0, rstart_ff}) begin
                  hi_in = {1'b0, rstart_ff};
               end
            end
         end

         pea_pkg::S_DECIDE: begin
            ladj_in  = found_ff && lend_ff == {1'b0, lo_ff};
            radj_in  = rfound_ff && {1'b0, rstart_ff} == hi_ff;
            delta_in = hi_ff - lo_ff;
            state_in = pea_pkg::S_MERGE;
         end

         pea_pkg::S_MERGE: begin
            addlen_in = (ladj_ff && radj_ff) ? delta_ff + rlen_ff : delta_ff;
            if (!ladj_ff && !radj_ff && !sfound_ff) begin
               status_in = pea_pkg::ST_FULL;
            end
            state_in = pea_pkg::S_WRITE;
         end

         // rewrite the chosen slots and track the largest extent
         pea_pkg::S_WRITE: begin
            ring_shift = 1'b1;
            if (status_ff == pea_pkg::ST_OK) begin
               if (op_ff == pea_pkg::OP_ALLOC) begin
                  if (cnt_ff == bidx_ff) begin
                     if (exact_ff) begin
                        w_valid = 1'b0;
                     end else begin
                        w_length = nlen_ff;
                     end
                  end
               end else begin
                  if (ladj_ff && cnt_ff == bidx_ff) begin
                     w_length = h_length + addlen_ff;
                  end
                  if (radj_ff && cnt_ff == ridx_ff) begin
                     if (ladj_ff) begin
                        w_valid = 1'b0;
                     end else begin
                        w_start  = lo_ff[A-1:0];
                        w_length = h_length + addlen_ff;
                     end
                  end
                  if (!ladj_ff && !radj_ff && cnt_ff == sidx_ff) begin
                     w_valid  = 1'b1;
                     w_start  = lo_ff[A-1:0];
                     w_length = delta_ff;
                  end
               end
            end
            base_largest = (cnt_ff == '0) ? '0 : largest_ff;
            largest_in = (w_valid && w_length > base_largest) ? w_length : base_largest;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in = '0;
               state_in = pea_pkg::S_DONE;
            end
         end

         pea_pkg::S_DONE: begin
            granted_in = '0;
            if (status_ff == pea_pkg::ST_OK) begin
               if (op_ff == pea_pkg::OP_ALLOC) begin
                  total_in   = total_ff - size_ff;
                  granted_in = exact_ff ? bstart_ff : bstart_ff + nlen_ff[A-1:0];
               end else begin
                  total_in = total_ff + delta_ff;
               end
            end
            rsp_status_in  = status_ff;
            rsp_total_in   = total_in;
            rsp_largest_in = largest_ff;
            rsp_valid_in   = 1'b1;
            state_in       = pea_pkg::S_IDLE;
         end

         default: begin
            state_in = pea_pkg::S_IDLE;
         end
      endcase
   end

   assign busy                   = (state_ff != pea_pkg::S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_granted_address    = granted_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_total_free_bytes   = rsp_total_ff;
   assign rsp_largest_free_bytes = rsp_largest_ff;

endmodule

`default_nettype wire
